// File: hdl/rmbb_pkg.sv
package rmbb_pkg;

  // sizing of the label store and the pixel grid
  localparam int LABEL_COUNT = 256;
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;

  // field widths
  localparam int LabelW = 8;
  localparam int CoordW = 10;
  localparam int CountW = 21;
  localparam int SumW   = 30;
  localparam int AddrW  = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;

  // saturation limits
  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [SumW-1:0]   SUM_MAX   = '1;
  localparam logic [CoordW-1:0] COORD_MAX = '1;

  // centroid divider: one quotient bit per cycle
  localparam int DivSteps = CoordW;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // one label's accumulated moments and box
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [SumW-1:0]   row_sum;
    logic [SumW-1:0]   col_sum;
    logic [CoordW-1:0] min_row;
    logic [CoordW-1:0] max_row;
    logic [CoordW-1:0] min_col;
    logic [CoordW-1:0] max_col;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    count:   '0,
    row_sum: '0,
    col_sum: '0,
    min_row: COORD_MAX,
    max_row: '0,
    min_col: COORD_MAX,
    max_col: '0
  };

  // readout request from the store to the divider
  typedef struct packed {
    logic   vld;
    logic   empty;
    entry_t entry;
  } rd_req_t;

  // one finished result
  typedef struct packed {
    logic [CountW-1:0] area;
    logic [CoordW-1:0] center_row;
    logic [CoordW-1:0] center_col;
    logic [CoordW-1:0] box_top;
    logic [CoordW-1:0] box_bottom;
    logic [CoordW-1:0] box_left;
    logic [CoordW-1:0] box_right;
    logic              is_empty;
  } result_t;

endpackage

// File: hdl/rmbb_ram.sv
module rmbb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rmbb_store.sv
module rmbb_store import rmbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic              op_i,
  input  logic [LabelW-1:0] label_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  output rd_req_t           rd_req_o
);

  // stage 1: request waits here for the ram read data
  logic              s1_vld_q;
  logic              s1_op_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic              s1_lab_ok_q;
  logic              s1_pix_ok_q;
  logic [CoordW-1:0] s1_row_q;
  logic [CoordW-1:0] s1_col_q;

  // per-entry valid bits; an invalid entry reads as the reset entry
  logic [LABEL_COUNT-1:0] vld_q;

  // last write, for a read that raced it
  logic             fwd_vld_q;
  logic [AddrW-1:0] fwd_addr_q;
  entry_t           fwd_data_q;

  logic [EntryW-1:0] ram_rdata;
  entry_t            cur;
  entry_t            upd;
  logic              fwd_hit;
  logic              do_write;
  logic              do_clear;
  logic [SumW:0]     row_sum_ext;
  logic [SumW:0]     col_sum_ext;
  logic              lab_ok;
  logic              pix_ok;

  // range checks at the input
  assign lab_ok = 32'(label_i) < LABEL_COUNT;
  assign pix_ok = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);

  rmbb_ram #(
    .Width (EntryW),
    .Depth (LABEL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (s1_addr_q),
    .wdata_i (upd),
    .re_i    (acc_i),
    .raddr_i (AddrW'(label_i)),
    .rdata_o (ram_rdata)
  );

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_op_q     <= op_i;
      s1_addr_q   <= AddrW'(label_i);
      s1_lab_ok_q <= lab_ok;
      s1_pix_ok_q <= pix_ok;
      s1_row_q    <= row_i;
      s1_col_q    <= col_i;
    end
  end

  // current entry: forwarded write, reset value or ram data
  assign fwd_hit = fwd_vld_q && (fwd_addr_q == s1_addr_q);

  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data_q;
    end else if (s1_lab_ok_q && vld_q[s1_addr_q]) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  // accumulate one pixel with saturating sums
  assign row_sum_ext = {1'b0, cur.row_sum} + (SumW+1)'(s1_row_q);
  assign col_sum_ext = {1'b0, cur.col_sum} + (SumW+1)'(s1_col_q);

  always_comb begin
    upd         = cur;
    upd.count   = cur.count + CountW'(1);
    upd.row_sum = row_sum_ext[SumW] ? SUM_MAX : row_sum_ext[SumW-1:0];
    upd.col_sum = col_sum_ext[SumW] ? SUM_MAX : col_sum_ext[SumW-1:0];
    if (s1_row_q < cur.min_row) begin
      upd.min_row = s1_row_q;
    end
    if (s1_row_q > cur.max_row) begin
      upd.max_row = s1_row_q;
    end
    if (s1_col_q < cur.min_col) begin
      upd.min_col = s1_col_q;
    end
    if (s1_col_q > cur.max_col) begin
      upd.max_col = s1_col_q;
    end
  end

  assign do_write = s1_vld_q && (s1_op_q == OP_ACCUM) && s1_lab_ok_q && s1_pix_ok_q &&
                    (cur.count != COUNT_MAX);
  assign do_clear = s1_vld_q && (s1_op_q == OP_READ) && s1_lab_ok_q;

  // readout request goes to the divider for one cycle
  always_comb begin
    rd_req_o.vld   = s1_vld_q && (s1_op_q == OP_READ);
    rd_req_o.empty = !s1_lab_ok_q || (cur.count == '0);
    rd_req_o.entry = cur;
  end

  // valid bits: set on write, cleared by a readout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (do_write) begin
        vld_q[s1_addr_q] <= 1'b1;
      end else if (do_clear) begin
        vld_q[s1_addr_q] <= 1'b0;
      end
      fwd_vld_q <= do_write || do_clear;
    end
  end

  // forwarding register for a back-to-back request to the same label
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= upd;
    end else if (do_clear) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= ENTRY_RESET;
    end
  end

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> vld_q[$past(s1_addr_q)])
    else $error("entry not valid after a write");

  a_clear_drops_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clear |=> !vld_q[$past(s1_addr_q)])
    else $error("entry still valid after a readout");

  a_fwd_follows_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_vld_q |-> $past(s1_vld_q))
    else $error("forwarding without an update in the previous cycle");

endmodule

// File: hdl/rmbb_div.sv
module rmbb_div import rmbb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  rd_req_t req_i,
  input  logic    take_i,
  output logic    res_valid_o,
  output logic    busy_o,
  output result_t res_o
);

  localparam logic [DivCntW-1:0] CntLast = DivCntW'(DivSteps - 1);

  div_state_e state_q;
  div_state_e state_d;

  logic [DivCntW-1:0] cnt_q;
  logic [SumW-1:0]    rem_r_q;
  logic [SumW-1:0]    rem_c_q;
  logic [SumW-1:0]    dsh_q;
  logic [CoordW-1:0]  quo_r_q;
  logic [CoordW-1:0]  quo_c_q;
  logic               empty_q;
  entry_t             ent_q;

  logic [SumW:0] diff_r;
  logic [SumW:0] diff_c;
  logic          ge_r;
  logic          ge_c;

  // one restoring step on both sums, shared divisor
  assign diff_r = {1'b0, rem_r_q} - {1'b0, dsh_q};
  assign diff_c = {1'b0, rem_c_q} - {1'b0, dsh_q};
  assign ge_r   = !diff_r[SumW];
  assign ge_c   = !diff_c[SumW];

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (req_i.vld) begin
          state_d = req_i.empty ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_q == CntLast) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  // datapath: load on start, one quotient bit per run cycle
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && req_i.vld) begin
      ent_q   <= req_i.entry;
      empty_q <= req_i.empty;
      rem_r_q <= req_i.entry.row_sum;
      rem_c_q <= req_i.entry.col_sum;
      dsh_q   <= SumW'(req_i.entry.count) << (DivSteps - 1);
      quo_r_q <= '0;
      quo_c_q <= '0;
      cnt_q   <= '0;
    end else if (state_q == DIV_RUN) begin
      if (ge_r) begin
        rem_r_q <= diff_r[SumW-1:0];
      end
      if (ge_c) begin
        rem_c_q <= diff_c[SumW-1:0];
      end
      quo_r_q <= {quo_r_q[CoordW-2:0], ge_r};
      quo_c_q <= {quo_c_q[CoordW-2:0], ge_c};
      dsh_q   <= dsh_q >> 1;
      cnt_q   <= cnt_q + DivCntW'(1);
    end
  end

  assign res_valid_o = (state_q == DIV_DONE);
  assign busy_o      = (state_q != DIV_IDLE);

  // an empty region reports zeros
  always_comb begin
    if (empty_q) begin
      res_o          = '0;
      res_o.is_empty = 1'b1;
    end else begin
      res_o.area       = ent_q.count;
      res_o.center_row = quo_r_q;
      res_o.center_col = quo_c_q;
      res_o.box_top    = ent_q.min_row;
      res_o.box_bottom = ent_q.max_row;
      res_o.box_left   = ent_q.min_col;
      res_o.box_right  = ent_q.max_col;
      res_o.is_empty   = 1'b0;
    end
  end

  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.vld |-> (state_q == DIV_IDLE))
    else $error("readout request while divider busy");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN) |-> (cnt_q <= CntLast))
    else $error("divider step count out of range");

  a_empty_skips_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_RUN) |-> !empty_q)
    else $error("divider running on an empty region");

endmodule

// File: hdl/region_moments_and_bounding_box_unit.sv
// channel | direction | handshake                   | fields
// in      | in        | in_valid_i / in_stall_o     | op, region_label, pixel_row, pixel_col
// out     | out       | out_valid_o / out_stall_i   | area, center_row/col, box_*, is_empty
//
// a pixel request is written from the store stage; pixels to the same label may follow back to back
// a readout passes the store stage and then the bit-serial divider, whose run state is skipped for an empty region
// input stalls while a readout is in the store stage or the divider is busy (running or holding a result)
// reset clears all valid bits at once; no clearing pass, a request may enter right after reset
// the output register keeps a result while out_stall_i is high; pixels still flow meanwhile unless the divider is busy
module region_moments_and_bounding_box_unit import rmbb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [LabelW-1:0] region_label_i,
  input  logic [CoordW-1:0] pixel_row_i,
  input  logic [CoordW-1:0] pixel_col_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CountW-1:0] area_o,
  output logic [CoordW-1:0] center_row_o,
  output logic [CoordW-1:0] center_col_o,
  output logic [CoordW-1:0] box_top_o,
  output logic [CoordW-1:0] box_bottom_o,
  output logic [CoordW-1:0] box_left_o,
  output logic [CoordW-1:0] box_right_o,
  output logic              is_empty_o
);

  rd_req_t rd_req;
  result_t div_res;
  result_t out_res_q;
  logic    out_valid_q;
  logic    div_valid;
  logic    div_busy;
  logic    in_acc;
  logic    out_load;

  // input handshake
  assign in_stall_o = rd_req.vld || div_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  rmbb_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .op_i     (op_i),
    .label_i  (region_label_i),
    .row_i    (pixel_row_i),
    .col_i    (pixel_col_i),
    .rd_req_o (rd_req)
  );

  rmbb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (rd_req),
    .take_i      (out_load),
    .res_valid_o (div_valid),
    .busy_o      (div_busy),
    .res_o       (div_res)
  );

  // output register
  assign out_load = div_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= div_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign area_o       = out_res_q.area;
  assign center_row_o = out_res_q.center_row;
  assign center_col_o = out_res_q.center_col;
  assign box_top_o    = out_res_q.box_top;
  assign box_bottom_o = out_res_q.box_bottom;
  assign box_left_o   = out_res_q.box_left;
  assign box_right_o  = out_res_q.box_right;
  assign is_empty_o   = out_res_q.is_empty;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_busy)
    else $error("request accepted while divider busy");

  a_empty_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (area_o == '0))
    else $error("empty region with nonzero area");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res_q)))
    else $error("stalled result changed");

endmodule

// File: test/region_moments_and_bounding_box_unit_test.sv
module region_moments_and_bounding_box_unit_test;
  import rmbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 3000;
  localparam int TailCycles    = 40;

  typedef struct {
    op_e               op;
    logic [LabelW-1:0] label;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    int                idle_pct;
    int                stall_pct;
  } request_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              op_i           = 1'b0;
  logic [LabelW-1:0] region_label_i = '0;
  logic [CoordW-1:0] pixel_row_i    = '0;
  logic [CoordW-1:0] pixel_col_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [CountW-1:0] area_o;
  logic [CoordW-1:0] center_row_o;
  logic [CoordW-1:0] center_col_o;
  logic [CoordW-1:0] box_top_o;
  logic [CoordW-1:0] box_bottom_o;
  logic [CoordW-1:0] box_left_o;
  logic [CoordW-1:0] box_right_o;
  logic              is_empty_o;

  region_moments_and_bounding_box_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .region_label_i (region_label_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .area_o         (area_o),
    .center_row_o   (center_row_o),
    .center_col_o   (center_col_o),
    .box_top_o      (box_top_o),
    .box_bottom_o   (box_bottom_o),
    .box_left_o     (box_left_o),
    .box_right_o    (box_right_o),
    .is_empty_o     (is_empty_o)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // per-label moments and box, tracked alongside the block
  logic [CountW-1:0] px_count   [LABEL_COUNT];
  logic [SumW-1:0]   row_total  [LABEL_COUNT];
  logic [SumW-1:0]   col_total  [LABEL_COUNT];
  logic [CoordW-1:0] top_row    [LABEL_COUNT];
  logic [CoordW-1:0] bottom_row [LABEL_COUNT];
  logic [CoordW-1:0] left_col   [LABEL_COUNT];
  logic [CoordW-1:0] right_col  [LABEL_COUNT];

  request_t pending_requests[$];
  result_t  pending_results[$];
  request_t cur_req;
  result_t  want;

  int idle_pct_fill;
  int stall_pct_fill;
  int stall_pct_now = 0;
  int n_queued      = 0;
  int n_pixels      = 0;
  int n_reads       = 0;
  int n_empty       = 0;
  int n_results     = 0;
  int n_errors      = 0;
  int idle_cycles   = 0;

  task automatic report_mismatch(input string msg);
    if (n_errors < 40) $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic compare_field(input int idx, input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", idx, name, got, exp_val));
  endtask

  task automatic clear_label(input int k);
    px_count[k]   = '0;
    row_total[k]  = '0;
    col_total[k]  = '0;
    top_row[k]    = COORD_MAX;
    bottom_row[k] = '0;
    left_col[k]   = COORD_MAX;
    right_col[k]  = '0;
  endtask

  function automatic logic [SumW-1:0] add_sat(input logic [SumW-1:0] a, input logic [CoordW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + b;
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SumW-1:0];
  endfunction

  // fold one accepted request into the store; a read queues its result
  task automatic update_moments(input request_t rq);
    result_t         res;
    logic [SumW-1:0] q_row;
    logic [SumW-1:0] q_col;
    int              k;
    bit              in_range;
    k        = int'(rq.label);
    in_range = k < LABEL_COUNT;
    if (rq.op == OP_ACCUM) begin
      if (!in_range || int'(rq.row) >= MAX_ROWS || int'(rq.col) >= MAX_COLS) return;
      if (px_count[k] == COUNT_MAX) return;
      n_pixels++;
      px_count[k]  = px_count[k] + 1'b1;
      row_total[k] = add_sat(row_total[k], rq.row);
      col_total[k] = add_sat(col_total[k], rq.col);
      if (rq.row < top_row[k])    top_row[k]    = rq.row;
      if (rq.row > bottom_row[k]) bottom_row[k] = rq.row;
      if (rq.col < left_col[k])   left_col[k]   = rq.col;
      if (rq.col > right_col[k])  right_col[k]  = rq.col;
    end else begin
      res = '0;
      n_reads++;
      if (!in_range || px_count[k] == '0) begin
        // empty region: flag only, all other fields zero
        res.is_empty = 1'b1;
        n_empty++;
        if (in_range) clear_label(k);
      end else begin
        q_row          = row_total[k] / SumW'(px_count[k]);
        q_col          = col_total[k] / SumW'(px_count[k]);
        res.area       = px_count[k];
        res.center_row = q_row[CoordW-1:0];
        res.center_col = q_col[CoordW-1:0];
        res.box_top    = top_row[k];
        res.box_bottom = bottom_row[k];
        res.box_left   = left_col[k];
        res.box_right  = right_col[k];
        clear_label(k);
      end
      pending_results.push_back(res);
    end
  endtask

  task automatic push_request(input op_e op, input int label, input int row, input int col);
    request_t rq;
    rq.op        = op;
    rq.label     = label[LabelW-1:0];
    rq.row       = row[CoordW-1:0];
    rq.col       = col[CoordW-1:0];
    rq.idle_pct  = idle_pct_fill;
    rq.stall_pct = stall_pct_fill;
    pending_requests.push_back(rq);
    n_queued++;
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > int'(COORD_MAX)) return int'(COORD_MAX);
    return v;
  endfunction

  // request driver: holds a stalled request, otherwise offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      op_i           <= 1'b0;
      region_label_i <= '0;
      pixel_row_i    <= '0;
      pixel_col_i    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) update_moments(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= pending_requests[0].idle_pct) begin
          cur_req = pending_requests.pop_front();
          in_valid_i     <= 1'b1;
          op_i           <= cur_req.op;
          region_label_i <= cur_req.label;
          pixel_row_i    <= cur_req.row;
          pixel_col_i    <= cur_req.col;
          stall_pct_now  <= cur_req.stall_pct;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stall, compare each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding", n_results));
        end else begin
          want = pending_results.pop_front();
          compare_field(n_results, "area", area_o, want.area);
          compare_field(n_results, "center_row", center_row_o, want.center_row);
          compare_field(n_results, "center_col", center_col_o, want.center_col);
          compare_field(n_results, "box_top", box_top_o, want.box_top);
          compare_field(n_results, "box_bottom", box_bottom_o, want.box_bottom);
          compare_field(n_results, "box_left", box_left_o, want.box_left);
          compare_field(n_results, "box_right", box_right_o, want.box_right);
          compare_field(n_results, "is_empty", is_empty_o, want.is_empty);
        end
        n_results++;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct_now);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int mix;
    int target;
    int kind;
    int nlab;
    int npx;
    int cr;
    int cc;
    int span;
    int lab;
    int labs[3];
    bit full_range;

    for (int k = 0; k < LABEL_COUNT; k++) clear_label(k);

    // directed: extremes, empty reads, read right after a pixel and vice versa
    idle_pct_fill  = 0;
    stall_pct_fill = 0;
    push_request(OP_READ,  0,    0,    0);
    push_request(OP_ACCUM, 0,    0,    0);
    push_request(OP_ACCUM, 0,    1023, 1023);
    push_request(OP_READ,  0,    1023, 1023);
    push_request(OP_READ,  0,    0,    0);
    push_request(OP_ACCUM, 255,  1023, 0);
    push_request(OP_ACCUM, 255,  0,    1023);
    push_request(OP_ACCUM, 255,  512,  511);
    push_request(OP_READ,  255,  341,  682);
    push_request(OP_ACCUM, 170,  341,  682);
    push_request(OP_ACCUM, 85,   682,  341);
    push_request(OP_ACCUM, 170,  341,  682);
    push_request(OP_READ,  170,  0,    0);
    push_request(OP_READ,  85,   1023, 0);
    push_request(OP_ACCUM, 1,    5,    7);
    push_request(OP_READ,  1,    0,    0);
    push_request(OP_ACCUM, 1,    9,    3);
    push_request(OP_READ,  1,    0,    0);
    push_request(OP_READ,  255,  0,    0);
    push_request(OP_ACCUM, 128,  1023, 1023);
    push_request(OP_READ,  128,  0,    0);

    // random: mostly region bursts followed by their reads, some noise
    for (int ph = 0; ph < 8; ph++) begin
      mix = ph % 4;
      case (mix)
        0: begin idle_pct_fill = 0;  stall_pct_fill = 0;  end
        1: begin idle_pct_fill = 84; stall_pct_fill = 0;  end
        2: begin idle_pct_fill = 0;  stall_pct_fill = 84; end
        default: begin idle_pct_fill = 16; stall_pct_fill = 16; end
      endcase
      target = n_queued + 240;
      while (n_queued < target) begin
        kind = $urandom_range(99);
        if (kind < 80) begin
          nlab = $urandom_range(1, 3);
          for (int i = 0; i < nlab; i++) labs[i] = $urandom_range(LABEL_COUNT - 1);
          npx        = $urandom_range(1, 24);
          full_range = ($urandom_range(3) == 0);
          cr         = $urandom_range(1023);
          cc         = $urandom_range(1023);
          span       = $urandom_range(1, 64);
          for (int p = 0; p < npx; p++) begin
            lab = labs[$urandom_range(nlab - 1)];
            if (full_range)
              push_request(OP_ACCUM, lab, $urandom_range(1023), $urandom_range(1023));
            else
              push_request(OP_ACCUM, lab,
                           clamp_coord(cr + $urandom_range(2 * span) - span),
                           clamp_coord(cc + $urandom_range(2 * span) - span));
          end
          for (int i = 0; i < nlab; i++)
            push_request(OP_READ, labs[i], $urandom_range(1023), $urandom_range(1023));
          // sometimes re-read a cleared label or hit it again right away
          if ($urandom_range(7) == 0)
            push_request(OP_READ, labs[0], $urandom_range(1023), $urandom_range(1023));
          else if ($urandom_range(7) == 0)
            push_request(OP_ACCUM, labs[0], $urandom_range(1023), $urandom_range(1023));
        end else if (kind < 90) begin
          push_request(OP_READ, $urandom_range(LABEL_COUNT - 1),
                       $urandom_range(1023), $urandom_range(1023));
        end else begin
          push_request(OP_ACCUM, $urandom_range(LABEL_COUNT - 1),
                       $urandom_range(1023), $urandom_range(1023));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("tb: %0d pixels and %0d region reads accepted, %0d of them on empty regions",
             n_pixels, n_reads, n_empty);
    $display("tb: %0d results compared over free, sparse, stalled and mixed traffic, %0d bad",
             n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rmbb_pkg.sv
hdl/rmbb_ram.sv
hdl/rmbb_store.sv
hdl/rmbb_div.sv
hdl/region_moments_and_bounding_box_unit.sv
test/region_moments_and_bounding_box_unit_test.sv
